// ----- src/eh_pkg.sv -----
package eh_pkg;

  // operation codes of an input request
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_BINNED    = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_REPORT_OK = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN     = 2'd0;
  localparam logic [1:0] CFG_STEP    = 2'd1;
  localparam logic [1:0] CFG_WIDTH   = 2'd2;
  localparam logic [1:0] CFG_ENTRIES = 2'd3;

  // saturation limits of the report sums
  localparam logic [61:0] SUM_CAP   = {62{1'b1}};
  localparam logic [41:0] TOTAL_MAX = {42{1'b1}};

  // work classes handed from the front to the back
  typedef enum logic [2:0] {
    K_ADD,
    K_UNDER,
    K_OVER,
    K_REPORT,
    K_CLEAR
  } kind_t;

  typedef struct packed {
    logic signed [31:0] min_value;
    logic [31:0]        step_inverse;
    logic [31:0]        bin_width;
    logic [10:0]        entry_count;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [9:0]         bin_index;
    logic signed [31:0] mean_energy;
    logic signed [31:0] peak_energy;
    logic [41:0]        total_count;
    logic [31:0]        below_count;
    logic [31:0]        above_count;
  } result_t;

  // clamp a wide signed sum to signed Q16.16
  function automatic logic [31:0] sat_q(input logic signed [50:0] v);
    logic [31:0] r;
    if (v > 51'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -51'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- src/eh_if.sv -----
interface eh_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] sample_value;
  modport source(output valid, operation, sample_value, input ready);
  modport sink(input valid, operation, sample_value, output ready);
endinterface

interface eh_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [9:0]         bin_index;
  logic signed [31:0] mean_energy;
  logic signed [31:0] peak_energy;
  logic [41:0]        total_count;
  logic [31:0]        below_count;
  logic [31:0]        above_count;
  modport source(output valid, status, bin_index, mean_energy, peak_energy,
                 total_count, below_count, above_count, input ready);
  modport sink(input valid, status, bin_index, mean_energy, peak_energy,
               total_count, below_count, above_count, output ready);
endinterface

// ----- src/eh_front.sv -----
module eh_front #(
  parameter int BINS = 1024,
  parameter int BAW  = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  eh_pkg::cfg_t   cfg,
  input  logic           hold,
  eh_in_if.sink          in_if,
  input  logic           q_full,
  output logic           q_push,
  output eh_pkg::kind_t  q_kind,
  output logic [BAW-1:0] q_bin
);
  import eh_pkg::*;

  logic               s1_v_r;
  logic [1:0]         s1_op_r;
  logic               s1_below_r;
  logic [63:0]        s1_prod_r;
  logic signed [32:0] diff;
  logic               accept;
  logic [63:0]        rounded;
  logic [31:0]        bin_full;
  logic [31:0]        n32;

  // offset from the range floor, exact in 33 bits
  assign diff = {in_if.sample_value[31], in_if.sample_value} -
                {cfg.min_value[31], cfg.min_value};

  assign in_if.ready = !hold && (!s1_v_r || !q_full);
  assign accept      = in_if.valid && in_if.ready;
  assign q_push      = s1_v_r && !q_full;

  // register the scaled offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= (in_if.operation != OP_NONE);
    end else if (q_push) begin
      s1_v_r <= 1'b0;
    end
    if (accept) begin
      s1_op_r    <= in_if.operation;
      s1_below_r <= diff[32];
      s1_prod_r  <= 64'(diff[31:0]) * 64'(cfg.step_inverse);
    end
  end

  // round half up and classify against the bins in use
  always_comb begin
    rounded  = s1_prod_r + 64'h0000_0000_8000_0000;
    bin_full = rounded[63:32];
    if (32'(cfg.entry_count) > 32'(BINS)) n32 = 32'(BINS);
    else n32 = 32'(cfg.entry_count);
    q_bin = bin_full[BAW-1:0];
    case (s1_op_r)
      OP_ADD: begin
        if (s1_below_r) q_kind = K_UNDER;
        else if (bin_full >= n32) q_kind = K_OVER;
        else q_kind = K_ADD;
      end
      OP_REPORT: q_kind = K_REPORT;
      default:   q_kind = K_CLEAR;
    endcase
  end

endmodule

// ----- src/eh_queue.sv -----
module eh_queue #(
  parameter int WIDTH = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      count_r;

  assign full  = (count_r == (AW+1)'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = slot_r[rd_ptr_r];

  // advance pointers and hold the fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
    if (push) slot_r[wr_ptr_r] <= din;
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue popped while empty");
  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue fill level lost a request");
`endif

endmodule

// ----- src/eh_back.sv -----
module eh_back #(
  parameter int BINS = 1024,
  parameter int CW   = 32,
  parameter int BAW  = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  eh_pkg::cfg_t   cfg,
  input  logic           q_empty,
  input  eh_pkg::kind_t  q_kind,
  input  logic [BAW-1:0] q_bin,
  output logic           q_pop,
  output logic           init_busy,
  eh_out_if.source       out_if
);
  import eh_pkg::*;

  localparam int NW = $clog2(BINS + 1);
  localparam int PW = CW + BAW;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_ADD_WR, S_SWEEP, S_WALK, S_DIV, S_SCALE,
    S_MUL_A, S_MUL_B, S_FIN, S_EMIT
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   mem [BINS];
  logic [CW-1:0]   rd_data_r;
  logic [BAW-1:0]  rd_addr;
  logic            mem_we;
  logic [BAW-1:0]  mem_wa;
  logic [CW-1:0]   mem_wd;

  logic [BAW-1:0]  addr_r;
  logic [BAW-1:0]  idx_r;
  logic [31:0]     below_r;
  logic [31:0]     above_r;
  result_t         pend_r;
  result_t         out_r;
  logic            out_v_r;

  logic [NW-1:0]   n_used;
  logic [NW-1:0]   rd_ptr_r;
  logic            issue;
  logic            v1_r, v2_r;
  logic [BAW-1:0]  i1_r, i2_r;
  logic [CW-1:0]   c2_r;
  logic [PW-1:0]   prod_r;
  logic [61:0]     tot_r, wsum_r;
  logic [CW-1:0]   best_r;
  logic [BAW-1:0]  best_id_r;
  logic [62:0]     sum_t;
  logic [65:0]     sum_w;

  logic [5:0]      cnt_r;
  logic [61:0]     dvd_r, rem_r, q_r;
  logic [62:0]     trial;
  logic            ge;
  logic [61:0]     srem_r;
  logic [33:0]     sq_r, sqf_r;
  logic [63:0]     sc_t, d1, d2;
  logic [61:0]     srem_nxt;
  logic [1:0]      inc;
  logic [31+BAW:0] mprod_r;
  logic signed [50:0] msum;
  logic            emit_go;

  // bins in use
  always_comb begin
    if (32'(cfg.entry_count) > 32'(BINS)) n_used = NW'(BINS);
    else n_used = NW'(cfg.entry_count);
  end

  assign issue     = (state_r == S_WALK) && (rd_ptr_r < n_used);
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign init_busy = (state_r == S_INIT);
  assign emit_go   = (state_r == S_EMIT) && (!out_v_r || out_if.ready);

  // memory port selection
  always_comb begin
    case (state_r)
      S_IDLE:  rd_addr = q_bin;
      S_WALK:  rd_addr = rd_ptr_r[BAW-1:0];
      default: rd_addr = addr_r;
    endcase
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = '0;
    case (state_r)
      S_INIT, S_SWEEP: mem_we = 1'b1;
      S_ADD_WR: begin
        mem_we = 1'b1;
        mem_wa = addr_r;
        mem_wd = (rd_data_r == {CW{1'b1}}) ? rd_data_r : rd_data_r + 1'b1;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[rd_addr];
  end

  // saturating report sums, one divider step, one scaler step and the result sum
  always_comb begin
    sum_t = 63'(tot_r) + 63'(c2_r);
    sum_w = 66'(wsum_r) + 66'(prod_r);
    trial = {rem_r, dvd_r[61]};
    ge    = (trial >= {1'b0, tot_r});
    d1    = 64'(tot_r);
    d2    = 64'({tot_r, 1'b0});
    sc_t  = 64'({srem_r, 1'b0}) + (cfg.bin_width[cnt_r[4:0]] ? 64'(rem_r) : 64'd0);
    if (sc_t >= d2) begin
      srem_nxt = 62'(sc_t - d2);
      inc      = 2'd2;
    end else if (sc_t >= d1) begin
      srem_nxt = 62'(sc_t - d1);
      inc      = 2'd1;
    end else begin
      srem_nxt = 62'(sc_t);
      inc      = 2'd0;
    end
    msum = 51'(cfg.min_value) + 51'(mprod_r) + 51'(sqf_r);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      idx_r   <= '0;
      below_r <= '0;
      above_r <= '0;
      out_v_r <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      if (emit_go) out_v_r <= 1'b1;
      else if (out_if.ready) out_v_r <= 1'b0;
      v1_r <= issue;
      v2_r <= v1_r;
      case (state_r)
        S_INIT: begin
          if (idx_r == BAW'(BINS - 1)) begin
            idx_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            case (q_kind)
              K_ADD: begin
                addr_r  <= q_bin;
                state_r <= S_ADD_WR;
              end
              K_UNDER: begin
                if (below_r != 32'hffff_ffff) below_r <= below_r + 1'b1;
                pend_r  <= '{status: ST_UNDERFLOW, default: '0};
                state_r <= S_EMIT;
              end
              K_OVER: begin
                if (above_r != 32'hffff_ffff) above_r <= above_r + 1'b1;
                pend_r  <= '{status: ST_OVERFLOW, default: '0};
                state_r <= S_EMIT;
              end
              K_REPORT: begin
                pend_r    <= '0;
                rd_ptr_r  <= '0;
                tot_r     <= '0;
                wsum_r    <= '0;
                best_r    <= '0;
                best_id_r <= '0;
                state_r   <= S_WALK;
              end
              default: begin
                pend_r  <= '0;
                below_r <= '0;
                above_r <= '0;
                idx_r   <= '0;
                state_r <= S_SWEEP;
              end
            endcase
          end
        end
        S_ADD_WR: begin
          pend_r  <= '{status: ST_BINNED, bin_index: 10'(addr_r), default: '0};
          state_r <= S_EMIT;
        end
        S_SWEEP: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == BAW'(BINS - 1)) begin
            pend_r.status <= ST_CLEARED;
            state_r <= S_EMIT;
          end
        end
        S_WALK: begin
          if (issue) rd_ptr_r <= rd_ptr_r + 1'b1;
          i1_r   <= rd_ptr_r[BAW-1:0];
          c2_r   <= rd_data_r;
          i2_r   <= i1_r;
          prod_r <= PW'(rd_data_r) * PW'(i1_r);
          if (v2_r) begin
            tot_r  <= (sum_t > 63'(SUM_CAP)) ? SUM_CAP : sum_t[61:0];
            wsum_r <= (sum_w > 66'(SUM_CAP)) ? SUM_CAP : sum_w[61:0];
            if (c2_r >= best_r) begin
              best_r    <= c2_r;
              best_id_r <= i2_r;
            end
          end
          if (!issue && !v1_r && !v2_r) begin
            if (tot_r == '0) begin
              pend_r.status <= ST_EMPTY;
              state_r <= S_EMIT;
            end else begin
              dvd_r   <= wsum_r;
              rem_r   <= '0;
              cnt_r   <= 6'd61;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r <= ge ? 62'(trial - {1'b0, tot_r}) : trial[61:0];
          dvd_r <= {dvd_r[60:0], 1'b0};
          q_r   <= {q_r[60:0], ge};
          if (cnt_r == '0) begin
            srem_r  <= '0;
            sq_r    <= '0;
            cnt_r   <= 6'd31;
            state_r <= S_SCALE;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_SCALE: begin
          srem_r <= srem_nxt;
          sq_r   <= {sq_r[32:0], 1'b0} + 34'(inc);
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= S_MUL_A;
        end
        S_MUL_A: begin
          mprod_r <= (32+BAW)'(cfg.bin_width) * (32+BAW)'(q_r[BAW-1:0]);
          sqf_r   <= sq_r + ((63'({srem_r, 1'b0}) >= 63'(tot_r)) ? 34'd1 : 34'd0);
          state_r <= S_MUL_B;
        end
        S_MUL_B: begin
          pend_r.mean_energy <= sat_q(msum);
          mprod_r <= (32+BAW)'(cfg.bin_width) * (32+BAW)'(best_id_r);
          sqf_r   <= '0;
          state_r <= S_FIN;
        end
        S_FIN: begin
          pend_r <= '{status:      ST_REPORT_OK,
                      mean_energy: pend_r.mean_energy,
                      peak_energy: sat_q(msum),
                      total_count: (tot_r > 62'(TOTAL_MAX)) ? TOTAL_MAX : tot_r[41:0],
                      default:     '0};
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (emit_go) begin
      out_r <= {pend_r.status, pend_r.bin_index, pend_r.mean_energy, pend_r.peak_energy,
                pend_r.total_count, below_r, above_r};
    end
  end

  assign out_if.valid       = out_v_r;
  assign out_if.status      = out_r.status;
  assign out_if.bin_index   = out_r.bin_index;
  assign out_if.mean_energy = out_r.mean_energy;
  assign out_if.peak_energy = out_r.peak_energy;
  assign out_if.total_count = out_r.total_count;
  assign out_if.below_count = out_r.below_count;
  assign out_if.above_count = out_r.above_count;

`ifndef ASSERT_OFF
  a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_INIT || state_r == S_SWEEP || state_r == S_ADD_WR))
    else $error("bin store written outside sweep or add");
  a_add_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD_WR) |-> ($past(state_r) == S_IDLE))
    else $error("add write not right after its read");
  a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !q_pop)
    else $error("request taken during the reset sweep");
`endif

endmodule

// ----- src/energy_histogram_engine_top.sv -----
// Energy histogram over signed Q16.16 samples with saturating underflow and
// overflow counters. Every request (add, report, clear) yields one result;
// operation code 3 is taken and dropped. The front scales and classifies a
// sample in one registered multiply and parks it in a four-deep queue, so the
// input keeps flowing while the back is busy until the queue fills. The back
// handles one request at a time: an add is a read-modify-write of the bin
// store, a clear sweeps all BINS entries, and a report walks the bins in use
// (entry_count, capped at BINS) through a 3-stage accumulate pipe and then,
// unless the total is zero, runs a 62-step divider and a 32-step scaler on
// the back's shared iteration counter. After reset the back clears the store
// in a pass over all BINS entries, during which no request is taken;
// configuration writes are taken at any time.
module energy_histogram_engine_top #(
  parameter int BINS        = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  eh_in_if.sink       in_if,
  eh_out_if.source    out_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import eh_pkg::*;

  localparam int BAW = $clog2(BINS);
  localparam int QW  = $bits(kind_t) + BAW;

  cfg_t           cfg_r;
  logic           hold;
  logic           q_full, q_push, q_pop, q_empty;
  kind_t          f_kind;
  logic [BAW-1:0] f_bin;
  logic [QW-1:0]  q_dout;
  kind_t          b_kind;
  logic [BAW-1:0] b_bin;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_value    <= '0;
      cfg_r.step_inverse <= 32'd65536;
      cfg_r.bin_width    <= 32'd65536;
      cfg_r.entry_count  <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN:     cfg_r.min_value    <= cfg_wdata;
        CFG_STEP:    cfg_r.step_inverse <= cfg_wdata;
        CFG_WIDTH:   cfg_r.bin_width    <= cfg_wdata;
        CFG_ENTRIES: cfg_r.entry_count  <= cfg_wdata[10:0];
        default:     cfg_r.entry_count  <= cfg_r.entry_count;
      endcase
    end
  end

  eh_front #(.BINS(BINS), .BAW(BAW)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .hold   (hold),
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_kind (f_kind),
    .q_bin  (f_bin)
  );

  eh_queue #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   ({f_kind, f_bin}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign b_kind = kind_t'(q_dout[QW-1:BAW]);
  assign b_bin  = q_dout[BAW-1:0];

  eh_back #(.BINS(BINS), .CW(COUNT_WIDTH), .BAW(BAW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_kind    (b_kind),
    .q_bin     (b_bin),
    .q_pop     (q_pop),
    .init_busy (hold),
    .out_if    (out_if)
  );

endmodule

// ----- dv/energy_histogram_engine_top_test.sv -----
module energy_histogram_engine_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import eh_pkg::*;

  localparam int NUM_BINS = 1024;
  localparam int SHOWN_MISMATCHES = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  eh_in_if  in_ch();
  eh_out_if out_ch();

  energy_histogram_engine_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch.sink),
    .out_if    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow histogram and register copy
  logic [31:0]        hist_bins [NUM_BINS];
  logic [31:0]        below_total;
  logic [31:0]        above_total;
  logic signed [31:0] lower_edge;
  logic [31:0]        step_inv;
  logic [31:0]        bin_w;
  logic [10:0]        bins_in_use;

  result_t expected_results [$];
  int mismatches = 0;
  int results_seen = 0;
  int status_seen [8];
  int burst_left = 0;
  int requests_sent = 0;

  function automatic logic [31:0] clamp_q(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] sum_capped(logic [63:0] a, logic [63:0] b);
    logic [63:0] cap;
    cap = {2'b00, SUM_CAP};
    return (b > cap - a) ? cap : a + b;
  endfunction

  // apply one request to the shadow histogram and return its result
  function automatic result_t histogram_predict(logic [1:0] op, logic signed [31:0] sample);
    result_t     r;
    int          n;
    logic [63:0] diff, bin, tot, wsum, best, whole, rem, off;
    logic [127:0] prod;
    int          best_id;
    r = '0;
    n = (bins_in_use > NUM_BINS) ? NUM_BINS : int'(bins_in_use);
    case (op)
      OP_ADD: begin
        if (sample < lower_edge) begin
          if (below_total != 32'hffff_ffff) below_total++;
          r.status = ST_UNDERFLOW;
        end else begin
          diff = 64'(longint'(sample) - longint'(lower_edge));
          prod = 128'(diff) * 128'(step_inv) + 128'(64'h8000_0000);
          bin = 64'(prod >> 32);
          if (bin >= 64'(n)) begin
            if (above_total != 32'hffff_ffff) above_total++;
            r.status = ST_OVERFLOW;
          end else begin
            if (hist_bins[bin] != 32'hffff_ffff) hist_bins[bin]++;
            r.status = ST_BINNED;
            r.bin_index = bin[9:0];
          end
        end
      end
      OP_REPORT: begin
        tot = 0;
        wsum = 0;
        best = 0;
        best_id = 0;
        for (int i = 0; i < n; i++) begin
          tot = sum_capped(tot, 64'(hist_bins[i]));
          wsum = sum_capped(wsum, 64'(hist_bins[i]) * 64'(i));
          if (64'(hist_bins[i]) >= best) begin
            best = 64'(hist_bins[i]);
            best_id = i;
          end
        end
        if (tot == 0) begin
          r.status = ST_EMPTY;
        end else begin
          whole = wsum / tot;
          rem = wsum % tot;
          prod = 128'(rem) * 128'(bin_w);
          // round half up of bin_width * rem / tot
          off = 64'(bin_w) * whole + 64'((2 * prod + 128'(tot)) / (2 * 128'(tot)));
          r.status = ST_REPORT_OK;
          r.mean_energy = clamp_q(longint'(lower_edge) + longint'(off));
          r.peak_energy = clamp_q(longint'(lower_edge) + longint'(64'(bin_w) * 64'(best_id)));
          r.total_count = (tot > 64'(TOTAL_MAX)) ? TOTAL_MAX : tot[41:0];
        end
      end
      default: begin
        foreach (hist_bins[i]) hist_bins[i] = '0;
        below_total = '0;
        above_total = '0;
        r.status = ST_CLEARED;
      end
    endcase
    r.below_count = below_total;
    r.above_count = above_total;
    return r;
  endfunction

  // receiver: a new stall pattern is drawn each time the phase counter wraps
  int stall_mode = 0;
  int stall_phase = 0;
  always @(negedge clk) begin
    if (stall_phase == 0) stall_mode <= $urandom_range(0, 3);
    stall_phase <= (stall_phase + 1) % 64;
    case (stall_mode)
      0, 1: out_ch.ready <= 1'b1;
      2: out_ch.ready <= $urandom_range(0, 1);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.bin_index, out_ch.mean_energy, out_ch.peak_energy,
              out_ch.total_count, out_ch.below_count, out_ch.above_count};
      results_seen++;
      status_seen[got.status]++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) $display("unexpected result %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.bin_index !== want.bin_index ||
            got.mean_energy !== want.mean_energy || got.peak_energy !== want.peak_energy ||
            got.total_count !== want.total_count || got.below_count !== want.below_count ||
            got.above_count !== want.above_count) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MIN:   lower_edge = value;
      CFG_STEP:  step_inv = value;
      CFG_WIDTH: bin_w = value;
      default:   bins_in_use = value[10:0];
    endcase
  endtask

  // hold the request until taken, then record its expected result unless it is a no-op
  task automatic send_request(logic [1:0] op, logic [31:0] sample);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.sample_value <= sample;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
    if (op != OP_NONE) expected_results.push_back(histogram_predict(op, sample));
  endtask

  // wait until every result is back and the block has settled
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // sample that mostly lands in a bin under the current settings
  function automatic logic [31:0] pick_sample();
    longint n, span, room;
    logic [63:0] r64;
    n = (bins_in_use > NUM_BINS) ? NUM_BINS : bins_in_use;
    span = (n << 32) / longint'(step_inv);
    room = 64'sd2147483647 - longint'(lower_edge) + 1;
    if (span > room) span = room;
    r64 = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0, 1, 2:
        return $urandom;
      3, 4:
        return clamp_q(longint'(lower_edge) + longint'(r64 % 64'(2 * span + 2)));
      default:
        if (span <= 0) return $urandom;
        else return 32'(longint'(lower_edge) + longint'(r64 % 64'(span)));
    endcase
  endfunction

  task automatic send_random(int count);
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 90) send_request(OP_ADD, pick_sample());
      else if (pick < 96) send_request(OP_REPORT, $urandom);
      else if (pick < 98) send_request(OP_CLEAR, $urandom);
      else send_request(OP_NONE, $urandom);
    end
  endtask

  task automatic set_all(logic [31:0] mn, logic [31:0] st, logic [31:0] bw, logic [31:0] ec);
    write_reg(CFG_MIN, mn);
    write_reg(CFG_STEP, st);
    write_reg(CFG_WIDTH, bw);
    write_reg(CFG_ENTRIES, ec);
  endtask

  // edges of binning, rounding, ties and empty report at reset settings
  task automatic test_directed();
    send_request(OP_REPORT, 32'h0);
    send_request(OP_ADD, 32'h0000_0000);
    send_request(OP_ADD, 32'h0000_7fff);
    send_request(OP_ADD, 32'h0000_8000);
    send_request(OP_ADD, 32'h03ff_0000);
    send_request(OP_ADD, 32'h03ff_8000);
    send_request(OP_ADD, 32'hffff_ffff);
    send_request(OP_ADD, 32'h7fff_ffff);
    send_request(OP_ADD, 32'h8000_0000);
    send_request(OP_REPORT, 32'hffff_ffff);
    send_request(OP_NONE, 32'h1234_5678);
    send_request(OP_CLEAR, 32'h0);
    send_request(OP_REPORT, 32'h0);
    send_request(OP_ADD, 32'h0005_0000);
    send_request(OP_ADD, 32'h0007_0000);
    send_request(OP_ADD, 32'h0005_0000);
    send_request(OP_ADD, 32'h0007_0000);
    send_request(OP_REPORT, 32'h0);
    send_request(OP_CLEAR, 32'h0);
    // every bin equal: the peak sits at the top bin
    wait_idle();
    write_reg(CFG_ENTRIES, 32'd3);
    send_request(OP_ADD, 32'h0000_0000);
    send_request(OP_ADD, 32'h0001_0000);
    send_request(OP_ADD, 32'h0002_0000);
    send_request(OP_REPORT, 32'h0);
    wait_idle();
  endtask

  // extremes of each register, including zero and oversized bin counts
  task automatic test_register_extremes();
    set_all(32'h8000_0000, 32'h0000_0001, 32'hffff_ffff, 32'd1024);
    send_random(25);
    wait_idle();
    set_all(32'h7fff_0000, 32'hffff_ffff, 32'h0000_0001, 32'd1);
    send_random(25);
    wait_idle();
    set_all(32'h7fff_ffff, 32'h0001_0000, 32'h0001_0000, 32'd16);
    send_random(20);
    wait_idle();
    set_all(32'hfff0_0000, 32'h0000_4000, 32'h0004_0000, 32'd0);
    send_random(20);
    wait_idle();
    set_all(32'h4000_0000, 32'h0010_0000, 32'h4000_0000, 32'd2047);
    send_random(30);
    wait_idle();
    set_all(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'd1024);
    send_random(30);
    wait_idle();
  endtask

  // long random runs under random settings, idling mid phase
  task automatic test_random_settings();
    for (int p = 0; p < 6; p++) begin
      set_all($urandom, $urandom_range(1, 32'h0008_0000), $urandom_range(1, 32'h0040_0000),
              ($urandom_range(0, 3) == 0) ? 32'd1024 : $urandom_range(1, 64));
      send_random(50);
      wait_idle();
      send_random(50);
      wait_idle();
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_NONE;
    in_ch.sample_value = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MIN;
    cfg_wdata = '0;
    foreach (hist_bins[i]) hist_bins[i] = '0;
    below_total = '0;
    above_total = '0;
    lower_edge = '0;
    step_inv = 32'h0001_0000;
    bin_w = 32'h0001_0000;
    bins_in_use = 11'd1024;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_extremes();
    test_random_settings();
    wait_idle();
    $display("%0d requests sent, %0d results checked: %0d binned, %0d under, %0d over,",
             requests_sent, results_seen, status_seen[ST_BINNED], status_seen[ST_UNDERFLOW],
             status_seen[ST_OVERFLOW]);
    $display("%0d reports, %0d empty reports, %0d clears; %0d mismatches",
             status_seen[ST_REPORT_OK], status_seen[ST_EMPTY], status_seen[ST_CLEARED],
             mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // drop the run if it hangs
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/eh_pkg.sv
src/eh_if.sv
src/eh_front.sv
src/eh_queue.sv
src/eh_back.sv
src/energy_histogram_engine_top.sv
dv/energy_histogram_engine_top_test.sv
